@@ src/sv39_page_table_walker_defines.svh @@
// Assertion macros for the Sv39 page-table walker.
// Included by the top level; no other dependencies.
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition a in this cycle requires b in the next cycle.
`define SV39_PTW_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sv39 walker: next-cycle check failed");

// Condition a requires b in the same cycle.
`define SV39_PTW_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sv39 walker: same-cycle check failed");

`else

`define SV39_PTW_ASSERT_NEXT(label, a, b)
`define SV39_PTW_ASSERT_NOW(label, a, b)

`endif

`endif

@@ src/sv39_ptw_pkg.sv @@
// Shared types and constants of the Sv39 page-table walker.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none

package sv39_ptw_pkg;

  // Sv39 geometry
  localparam int WALK_LEVELS = 3;
  localparam int PAGE_SHIFT  = 12;
  localparam int SLOT_BITS   = 9;
  localparam int SLOTS_PER_PAGE = 1 << SLOT_BITS;
  localparam int VA_BITS     = SLOT_BITS * WALK_LEVELS + PAGE_SHIFT - 1;
  localparam int PPN_W       = 44;
  localparam int PPN_LSB     = 10;
  localparam int ENTRY_W     = 64;
  localparam int PA_W        = 56;
  localparam int BIT_VALID   = 0;
  localparam int BIT_USER    = 4;
  localparam logic [1:0] LEVEL_TOP = 2'(WALK_LEVELS - 1);

  // Op codes
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROOT   = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_RANGE    = 3'd1,
    STATUS_UNMAPPED = 3'd2,
    STATUS_NOT_USER = 3'd3,
    STATUS_OUTSIDE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } ptw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear_write;   // write zero at the clear pointer, advance it
    logic       entry_write;   // write entry_value at entry_index if in range
    logic       read;          // issue a table read at the walk address
    logic       load_va;       // capture the virtual address
    logic       walk_src;      // 0: root page and input address, 1: entry and held address
    logic [1:0] slot_level;    // level whose slot forms the read address
    logic       result_load;   // present a result next cycle
    status_t    result_status;
    logic       result_pa;     // result carries the entry page number
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic va_high;
    logic win_out;
    logic entry_valid;
    logic entry_user;
  } ptw_stat_t;

  // Nine-bit slot of a virtual address at a level
  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [VA_BITS-1:0] va,
                                                   input logic [1:0] lvl);
    logic [SLOT_BITS-1:0] s;
    unique case (lvl)
      2'd0:    s = va[PAGE_SHIFT +: SLOT_BITS];
      2'd1:    s = va[PAGE_SHIFT + SLOT_BITS +: SLOT_BITS];
      // top slot has only eight bits; the top address bit is always clear
      default: s = SLOT_BITS'(va[VA_BITS-1:PAGE_SHIFT + 2 * SLOT_BITS]);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/sv39_page_table_walker.sv @@
// Sv39 page-table walker over a windowed table store: top level.
// Uses sv39_ptw_pkg, sv39_ptw_ctrl, sv39_ptw_datapath and the assertion header.
//
// An item is taken when start is high and busy is low. A table write (op 0)
// and a translation that faults before any table read give their result in
// the next cycle; a full translation goes through three dependent table reads,
// each through the store's registered read port (one per cycle), and then the
// result register. The result is shown for one cycle on done, status and
// physical_address and cannot be held off; busy is already low in that cycle,
// so the next item may be taken there. After reset the store is cleared one
// entry a cycle, all TABLE_PAGES * 512 entries (8192 at the default), with
// busy high; configuration writes are taken at any time.
`default_nettype none

`include "sv39_page_table_walker_defines.svh"

module sv39_page_table_walker #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic                           cfg_index,
  input  wire logic [sv39_ptw_pkg::PPN_W-1:0] cfg_data,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           op,
  input  wire logic [63:0]                    virtual_address,
  input  wire logic [12:0]                    entry_index,
  input  wire logic [63:0]                    entry_value,
  output logic                                done,
  output logic [2:0]                          status,
  output logic [55:0]                         physical_address
);

  import sv39_ptw_pkg::*;

  ptw_cmd_t  cmd;
  ptw_stat_t stat;

  sv39_ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sv39_ptw_datapath #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .virtual_address  (virtual_address),
    .entry_index      (entry_index),
    .entry_value      (entry_value),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .status           (status),
    .physical_address (physical_address)
  );

  // Checks
  `SV39_PTW_ASSERT_NEXT(a_write_result, start && !busy && op == OP_WRITE, done && status == STATUS_OK)
  `SV39_PTW_ASSERT_NEXT(a_range_fault, start && !busy && op == OP_TRANSLATE && (|virtual_address[63:VA_BITS]), done && status == STATUS_RANGE)
  `SV39_PTW_ASSERT_NOW(a_fault_pa_zero, done && status != STATUS_OK, physical_address == '0)
  `SV39_PTW_ASSERT_NOW(a_clear_after_reset, $past(rst), busy)

endmodule

`default_nettype wire

@@ src/sv39_ptw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sv39_ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/sv39_ptw_datapath.sv @@
// Datapath of the walker: config registers, table store, window check,
// clear pointer and result registers. Uses sv39_ptw_pkg and sv39_ptw_ram.
`default_nettype none

module sv39_ptw_datapath #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic                              cfg_index,
  input  wire logic [sv39_ptw_pkg::PPN_W-1:0]    cfg_data,
  input  wire logic [63:0]                       virtual_address,
  input  wire logic [12:0]                       entry_index,
  input  wire logic [sv39_ptw_pkg::ENTRY_W-1:0]  entry_value,
  input  wire sv39_ptw_pkg::ptw_cmd_t            cmd,
  output sv39_ptw_pkg::ptw_stat_t                stat,
  output logic                                   done,
  output logic [2:0]                             status,
  output logic [sv39_ptw_pkg::PA_W-1:0]          physical_address
);

  import sv39_ptw_pkg::*;

  localparam int DEPTH  = TABLE_PAGES * SLOTS_PER_PAGE;
  localparam int ADDR_W = $clog2(TABLE_PAGES) + SLOT_BITS;

  logic [PPN_W-1:0]   root_page;
  logic [PPN_W-1:0]   window_base;
  logic [VA_BITS-1:0] va_reg;
  logic [ADDR_W-1:0]  clear_addr;
  logic [ENTRY_W-1:0] rd_data;
  status_t            status_reg;

  logic [PPN_W-1:0]         walk_page;
  logic [VA_BITS-1:0]       walk_va;
  logic [SLOT_BITS-1:0]     walk_slot;
  logic [PPN_W:0]           page_off;
  logic [PPN_W+SLOT_BITS-1:0] rd_full;
  logic [ADDR_W-1:0]        rd_addr;
  logic [31:0]              idx_ext;
  logic                     idx_in_range;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [PPN_W-1:0]         entry_ppn;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_page   <= '0;
      window_base <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROOT:   root_page   <= cfg_data;
        CFG_WINDOW: window_base <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Held virtual address for the later levels
  always_ff @(posedge clk) begin
    if (cmd.load_va) begin
      va_reg <= virtual_address[VA_BITS-1:0];
    end
  end

  // Clear pointer for the pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_write && !stat.clear_done) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // Walk address: table page against the window, then page and slot
  assign entry_ppn = rd_data[PPN_LSB +: PPN_W];
  assign walk_page = cmd.walk_src ? entry_ppn : root_page;
  assign walk_va   = cmd.walk_src ? va_reg : virtual_address[VA_BITS-1:0];
  assign walk_slot = slot_of(walk_va, cmd.slot_level);
  assign page_off  = {1'b0, walk_page} - {1'b0, window_base};
  assign rd_full   = {page_off[PPN_W-1:0], walk_slot};
  assign rd_addr   = rd_full[ADDR_W-1:0];

  // Entry write port, shared with the clear pass
  assign idx_ext      = 32'(entry_index);
  assign idx_in_range = idx_ext < 32'(DEPTH);
  assign ram_we    = cmd.clear_write | (cmd.entry_write & idx_in_range);
  assign ram_waddr = cmd.clear_write ? clear_addr : idx_ext[ADDR_W-1:0];
  assign ram_wdata = cmd.clear_write ? '0 : entry_value;

  sv39_ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Status to the controller
  always_comb begin
    stat.clear_done  = (clear_addr == ADDR_W'(DEPTH - 1));
    stat.va_high     = |virtual_address[63:VA_BITS];
    stat.win_out     = page_off[PPN_W] | (page_off[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
    stat.entry_valid = rd_data[BIT_VALID];
    stat.entry_user  = rd_data[BIT_USER];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.result_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      status_reg       <= cmd.result_status;
      physical_address <= cmd.result_pa ? {entry_ppn, {PAGE_SHIFT{1'b0}}} : '0;
    end
  end

  assign status = status_reg;

endmodule

`default_nettype wire

@@ src/sv39_ptw_ctrl.sv @@
// Controller of the walker: clear pass, op dispatch and level sequencing.
// Uses sv39_ptw_pkg; drives the datapath through ptw_cmd_t.
`default_nettype none

module sv39_ptw_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    op,
  input  wire sv39_ptw_pkg::ptw_stat_t stat,
  output sv39_ptw_pkg::ptw_cmd_t       cmd,
  output logic                         busy
);

  import sv39_ptw_pkg::*;

  ptw_state_t state, state_next;
  logic [1:0] level, level_next;

  // State and level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    level_next = level;
    cmd = '0;
    cmd.result_status = STATUS_OK;
    cmd.slot_level = LEVEL_TOP;

    unique case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          unique case (op)
            OP_WRITE: begin
              cmd.entry_write   = 1'b1;
              cmd.result_load   = 1'b1;
              cmd.result_status = STATUS_OK;
            end
            default: begin
              // translate: top-level read straight from the root page
              priority if (stat.va_high) begin
                cmd.result_load   = 1'b1;
                cmd.result_status = STATUS_RANGE;
              end else if (stat.win_out) begin
                cmd.result_load   = 1'b1;
                cmd.result_status = STATUS_OUTSIDE;
              end else begin
                cmd.read    = 1'b1;
                cmd.load_va = 1'b1;
                level_next  = LEVEL_TOP;
                state_next  = ST_WALK;
              end
            end
          endcase
        end
      end

      ST_WALK: begin
        // entry of the current level is on the store output
        cmd.walk_src   = 1'b1;
        cmd.slot_level = (level == 2'd0) ? 2'd0 : level - 2'd1;
        priority if (!stat.entry_valid) begin
          cmd.result_load   = 1'b1;
          cmd.result_status = STATUS_UNMAPPED;
          state_next        = ST_IDLE;
        end else if (level == 2'd0) begin
          cmd.result_load   = 1'b1;
          cmd.result_status = stat.entry_user ? STATUS_OK : STATUS_NOT_USER;
          cmd.result_pa     = stat.entry_user;
          state_next        = ST_IDLE;
        end else if (stat.win_out) begin
          cmd.result_load   = 1'b1;
          cmd.result_status = STATUS_OUTSIDE;
          state_next        = ST_IDLE;
        end else begin
          cmd.read   = 1'b1;
          level_next = level - 2'd1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire
